@@ rtl/core/qtmp_pkg.sv @@
// ----------------------------------------------------------------------------
// qtmp_pkg
// Shared types and constants of the quarter-turn motion profiler: fixed point
// format, angle limits, mode codes, request codes and the interface structs.
// ----------------------------------------------------------------------------
package qtmp_pkg;

	localparam int FRAC_BITS = 16;

	localparam int ANGLE_W = 18;
	localparam int SPEED_W = 20;
	localparam int ACCEL_W = 18;
	localparam int TIMER_W = 24;
	localparam int DT_W    = 16;
	localparam int OUT_W   = 17;

	localparam int MUL_W  = 20;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DIV_QW = 18;
	localparam int DIV_DW = 40;

	localparam longint unsigned RND_HALF_L  = 64'd1 << (31 - FRAC_BITS);
	localparam longint unsigned HALF_PI_L   = (64'd6746518852 + RND_HALF_L) >> (32 - FRAC_BITS);
	localparam longint unsigned EPS_SNAP_L  = (64'd429497 + RND_HALF_L) >> (32 - FRAC_BITS);
	localparam longint unsigned EPS_CMD_L   = (64'd4294967 + RND_HALF_L) >> (32 - FRAC_BITS);

	localparam logic [ANGLE_W-1:0] HALF_PI_Q = ANGLE_W'(HALF_PI_L);
	localparam logic [ANGLE_W-1:0] EPS_SNAP  = ANGLE_W'(EPS_SNAP_L);
	localparam logic [ANGLE_W-1:0] EPS_CMD   = ANGLE_W'(EPS_CMD_L);

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
	localparam logic [ACCEL_W-1:0] ACCEL_MAX = '1;

	localparam logic [1:0] CFG_ACCEL_LIMIT = 2'd0;
	localparam logic [1:0] CFG_SPEED_LIMIT = 2'd1;
	localparam logic [1:0] CFG_LOCK_WAIT   = 2'd2;
	localparam logic [1:0] CFG_JERK_RATE   = 2'd3;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_UNL_L = 3'd1,
		MODE_UNL_R = 3'd2,
		MODE_ROT_L = 3'd3,
		MODE_ROT_R = 3'd4,
		MODE_LCK_L = 3'd5,
		MODE_LCK_R = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_LEFT  = 2'd1,
		REQ_RIGHT = 2'd2
	} req_t;

	typedef struct packed {
		logic [ACCEL_W-1:0] accel_limit;
		logic [SPEED_W-1:0] speed_limit;
		logic [TIMER_W-1:0] lock_wait;
		logic [ACCEL_W-1:0] jerk_rate;
	} cfg_t;

	typedef struct packed {
		logic              lock_pulse;
		logic              unlock_pulse;
		mode_t             motion_mode;
		logic [OUT_W-1:0]  turn_fraction;
		logic [OUT_W-1:0]  turn_angle;
	} res_t;

endpackage

@@ rtl/core/qtmp_mul.sv @@
// ----------------------------------------------------------------------------
// qtmp_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module qtmp_mul
	import qtmp_pkg::*;
(
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] p
);

	logic [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

@@ rtl/core/qtmp_div.sv @@
// ----------------------------------------------------------------------------
// qtmp_div
// Restoring divider, one quotient bit per cycle. The dividend must be below
// the divisor shifted up by the quotient width, so the quotient fits.
// ----------------------------------------------------------------------------
module qtmp_div
	import qtmp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_DW-1:0] dividend,
	input  logic [DIV_QW-1:0] divisor,
	output logic              done,
	output logic [DIV_QW-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_QW + 1);
	localparam logic [CNT_W-1:0] STEPS = CNT_W'(DIV_QW);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DIV_QW-1:0] rem_q;
	logic [DIV_QW-1:0] sh_q;
	logic [DIV_QW-1:0] den_q;
	logic [DIV_QW:0]   trial;
	logic              ge;

	always_comb begin
		trial = {rem_q, sh_q[DIV_QW-1]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= STEPS;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DIV_QW +: DIV_QW];
			sh_q  <= dividend[DIV_QW-1:0];
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DIV_QW'(trial - {1'b0, den_q}) : trial[DIV_QW-1:0];
			sh_q  <= {sh_q[DIV_QW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

@@ rtl/core/qtmp_core.sv @@
// ----------------------------------------------------------------------------
// qtmp_core
// Motion state and sequencer: dwell timing, arrival check, accelerate or
// brake decision and the angle step, all through one multiplier and one
// divider, then the angle fraction by a reciprocal multiply and a one step fix.
// ----------------------------------------------------------------------------
module qtmp_core
	import qtmp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      req,
	input  logic [DT_W-1:0] dt,
	input  cfg_t            cfg,
	output logic            ready,
	output logic            res_valid,
	input  logic            res_ready,
	output res_t            res
);

	typedef enum logic [19:0] {
		ST_IDLE   = 20'h00001,
		ST_CMD    = 20'h00002,
		ST_ARRIVE = 20'h00004,
		ST_MDA    = 20'h00008,
		ST_MSS    = 20'h00010,
		ST_CMP    = 20'h00020,
		ST_JRK    = 20'h00040,
		ST_ACC    = 20'h00080,
		ST_ACC2   = 20'h00100,
		ST_SPD    = 20'h00200,
		ST_DIVW   = 20'h00400,
		ST_DROP   = 20'h00800,
		ST_BRK    = 20'h01000,
		ST_STEP   = 20'h02000,
		ST_MOVE   = 20'h04000,
		ST_FRAC   = 20'h08000,
		ST_FEST   = 20'h10000,
		ST_FMUL   = 20'h20000,
		ST_FFIX   = 20'h40000,
		ST_OUT    = 20'h80000
	} state_t;

	localparam longint unsigned FRAC_RECIP_L = (64'd1 << (FRAC_BITS + MUL_W)) / HALF_PI_L;
	localparam logic [MUL_W-1:0]  FRAC_RECIP = MUL_W'(FRAC_RECIP_L);
	localparam logic [PROD_W-1:0] FRAC_RND   = PROD_W'(1) << (MUL_W - 1);
	localparam logic [PROD_W-1:0] FRAC_BIAS  = PROD_W'(HALF_PI_Q >> 1);

	state_t              state_q;
	mode_t               mode_q;
	req_t                req_q;
	logic [DT_W-1:0]     dt_q;
	logic [ANGLE_W-1:0]  angle_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [ACCEL_W-1:0]  accel_q;
	logic [TIMER_W-1:0]  timer_q;
	logic [ANGLE_W-1:0]  diff_q;
	logic [PROD_W+1:0]   lhs_q;
	logic [OUT_W-1:0]    frac_q;
	logic                unlock_q;
	logic                lock_q;

	logic                right;
	logic [ANGLE_W-1:0]  target;
	logic [TIMER_W:0]    dwell_sum;
	logic [TIMER_W-1:0]  dwell_sat;
	logic                dwell_end;
	logic                arrived;
	logic [PROD_W+1:0]   rhs;
	logic                accel_go;
	logic [DIV_QW-1:0]   den;
	logic                dec_sat;
	logic [ACCEL_W-1:0]  prod_acc;
	logic [SPEED_W-1:0]  prod_spd;
	logic [ACCEL_W:0]    acc_sum;
	logic [SPEED_W:0]    spd_sum;
	logic [SPEED_W:0]    ang_sum;
	logic [PROD_W-1:0]   est_sum;
	logic [OUT_W-1:0]    frac_est;
	logic [PROD_W-1:0]   frac_num;
	logic                frac_up;

	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic                div_start;
	logic [DIV_DW-1:0]   div_dividend;
	logic [DIV_QW-1:0]   div_divisor;
	logic                div_done;
	logic [DIV_QW-1:0]   div_quo;

	always_comb begin
		right     = (mode_q == MODE_ROT_R);
		target    = right ? HALF_PI_Q : '0;
		dwell_sum = (TIMER_W + 1)'(timer_q) + (TIMER_W + 1)'(dt_q);
		dwell_sat = dwell_sum[TIMER_W] ? TIMER_MAX : dwell_sum[TIMER_W-1:0];
		dwell_end = dwell_sum > {1'b0, cfg.lock_wait};
		arrived   = right ? ((ANGLE_W + 1)'(angle_q) + (ANGLE_W + 1)'(EPS_SNAP)
			>= (ANGLE_W + 1)'(HALF_PI_Q)) : (angle_q <= EPS_SNAP);
		rhs       = (PROD_W + 2)'(mul_p) + ((PROD_W + 2)'(mul_p) << 1);
		accel_go  = lhs_q > rhs;
		den       = {diff_q[DIV_QW-2:0], 1'b0};
		dec_sat   = mul_p >= (PROD_W'(den) << DIV_QW);
		prod_acc  = mul_p[FRAC_BITS +: ACCEL_W];
		prod_spd  = mul_p[FRAC_BITS +: SPEED_W];
		acc_sum   = (ACCEL_W + 1)'(accel_q) + (ACCEL_W + 1)'(prod_acc);
		spd_sum   = (SPEED_W + 1)'(speed_q) + (SPEED_W + 1)'(prod_acc);
		ang_sum   = (SPEED_W + 1)'(angle_q) + (SPEED_W + 1)'(prod_spd);
		est_sum   = mul_p + FRAC_RND;
		frac_est  = est_sum[MUL_W +: OUT_W];
		frac_num  = (PROD_W'(angle_q) << FRAC_BITS) + FRAC_BIAS;
		frac_up   = (mul_p + PROD_W'(HALF_PI_Q)) <= frac_num;
	end

	// multiplier operand select, product read one state later
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MDA: begin
				mul_a = MUL_W'(diff_q);
				mul_b = MUL_W'(cfg.accel_limit);
			end
			ST_MSS: begin
				mul_a = speed_q;
				mul_b = speed_q;
			end
			ST_JRK: begin
				mul_a = MUL_W'(cfg.jerk_rate);
				mul_b = MUL_W'(dt_q);
			end
			ST_ACC2, ST_DROP: begin
				mul_a = MUL_W'(accel_q);
				mul_b = MUL_W'(dt_q);
			end
			ST_STEP: begin
				mul_a = speed_q;
				mul_b = MUL_W'(dt_q);
			end
			ST_FRAC: begin
				mul_a = MUL_W'(angle_q);
				mul_b = FRAC_RECIP;
			end
			ST_FMUL: begin
				mul_a = MUL_W'(frac_q);
				mul_b = MUL_W'(HALF_PI_Q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_start    = (state_q == ST_CMP) && !accel_go && (diff_q > EPS_SNAP) && !dec_sat;
		div_dividend = DIV_DW'(mul_p);
		div_divisor  = den;
	end

	qtmp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	qtmp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_IDLE;
			req_q    <= REQ_TICK;
			dt_q     <= '0;
			angle_q  <= '0;
			speed_q  <= '0;
			accel_q  <= '0;
			timer_q  <= '0;
			diff_q   <= '0;
			lhs_q    <= '0;
			frac_q   <= '0;
			unlock_q <= 1'b0;
			lock_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q    <= req_t'(req);
						dt_q     <= dt;
						unlock_q <= 1'b0;
						lock_q   <= 1'b0;
						state_q  <= ST_CMD;
					end
				end
				ST_CMD: begin
					unique case (req_q)
						REQ_LEFT: begin
							state_q <= ST_FRAC;
							if (angle_q > EPS_CMD && mode_q != MODE_UNL_L) begin
								mode_q   <= MODE_UNL_L;
								timer_q  <= '0;
								unlock_q <= 1'b1;
							end
						end
						REQ_RIGHT: begin
							state_q <= ST_FRAC;
							if (angle_q <= HALF_PI_Q - EPS_CMD && mode_q != MODE_UNL_R) begin
								mode_q   <= MODE_UNL_R;
								timer_q  <= '0;
								unlock_q <= 1'b1;
							end
						end
						REQ_TICK: begin
							state_q <= ST_ARRIVE;
							if (mode_q == MODE_UNL_L || mode_q == MODE_UNL_R) begin
								timer_q <= dwell_sat;
								if (dwell_end) begin
									mode_q <= (mode_q == MODE_UNL_L) ? MODE_ROT_L : MODE_ROT_R;
								end
							end else if (mode_q == MODE_LCK_L || mode_q == MODE_LCK_R) begin
								timer_q <= dwell_sat;
								if (dwell_end) begin
									mode_q <= MODE_IDLE;
								end
							end
						end
						default: begin
							state_q <= ST_FRAC;
						end
					endcase
				end
				ST_ARRIVE: begin
					if (mode_q != MODE_ROT_L && mode_q != MODE_ROT_R) begin
						state_q <= ST_FRAC;
					end else if (arrived) begin
						angle_q <= target;
						speed_q <= '0;
						accel_q <= '0;
						timer_q <= '0;
						mode_q  <= right ? MODE_LCK_R : MODE_LCK_L;
						lock_q  <= 1'b1;
						state_q <= ST_FRAC;
					end else begin
						diff_q  <= right ? HALF_PI_Q - angle_q : angle_q;
						state_q <= ST_MDA;
					end
				end
				ST_MDA: begin
					state_q <= ST_MSS;
				end
				ST_MSS: begin
					lhs_q   <= {mul_p, 2'b00};
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (accel_go) begin
						state_q <= ST_JRK;
					end else if (diff_q <= EPS_SNAP) begin
						accel_q <= '0;
						speed_q <= '0;
						angle_q <= target;
						state_q <= ST_FRAC;
					end else if (dec_sat) begin
						accel_q <= ACCEL_MAX;
						state_q <= ST_DROP;
					end else begin
						state_q <= ST_DIVW;
					end
				end
				ST_JRK: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					accel_q <= (acc_sum > (ACCEL_W + 1)'(cfg.accel_limit)) ?
						cfg.accel_limit : acc_sum[ACCEL_W-1:0];
					state_q <= ST_ACC2;
				end
				ST_ACC2: begin
					state_q <= ST_SPD;
				end
				ST_SPD: begin
					speed_q <= (spd_sum > (SPEED_W + 1)'(cfg.speed_limit)) ?
						cfg.speed_limit : spd_sum[SPEED_W-1:0];
					state_q <= ST_STEP;
				end
				ST_DIVW: begin
					if (div_done) begin
						accel_q <= div_quo;
						state_q <= ST_DROP;
					end
				end
				ST_DROP: begin
					state_q <= ST_BRK;
				end
				ST_BRK: begin
					if (SPEED_W'(prod_acc) >= speed_q) begin
						speed_q <= '0;
						angle_q <= target;
						state_q <= ST_FRAC;
					end else begin
						speed_q <= speed_q - SPEED_W'(prod_acc);
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					if (right) begin
						angle_q <= (ang_sum > (SPEED_W + 1)'(HALF_PI_Q)) ?
							HALF_PI_Q : ang_sum[ANGLE_W-1:0];
					end else begin
						angle_q <= (SPEED_W'(angle_q) <= prod_spd) ?
							'0 : angle_q - ANGLE_W'(prod_spd);
					end
					state_q <= ST_FRAC;
				end
				ST_FRAC: begin
					state_q <= ST_FEST;
				end
				// rounded estimate, low by at most one
				ST_FEST: begin
					frac_q  <= frac_est;
					state_q <= ST_FMUL;
				end
				ST_FMUL: begin
					state_q <= ST_FFIX;
				end
				ST_FFIX: begin
					if (frac_up) begin
						frac_q <= frac_q + OUT_W'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ready     = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);

	always_comb begin
		res.turn_angle    = angle_q[OUT_W-1:0];
		res.turn_fraction = frac_q;
		res.motion_mode   = mode_q;
		res.unlock_pulse  = unlock_q;
		res.lock_pulse    = lock_q;
	end

`ifndef NO_ASSERTIONS
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_q <= HALF_PI_Q)
		else $error("angle beyond quarter turn");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVW))
		else $error("divider finished with no state waiting for it");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("pending result changed");

	a_lock_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.lock_pulse) |->
		(mode_q == MODE_LCK_L || mode_q == MODE_LCK_R))
		else $error("lock pulse outside lock mode");
`endif

endmodule

@@ rtl/core/quarter_turn_motion_profiler.sv @@
// ----------------------------------------------------------------------------
// quarter_turn_motion_profiler
// Turntable motion profiler between zero and a quarter turn: configuration
// registers, request and result channels around the sequenced motion core.
//
// channel  handshake            payload
// s_*      s_tvalid / s_tready  tdata frame_dt, tuser req_type
// m_*      m_tvalid / m_tready  tdata angle, fraction, mode, pulses
// cfg_*    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a rotate command goes straight to the fraction states, a tick first runs the arrival
// check and the motion steps, and a braking tick also waits on the deceleration divide;
// the motion steps share one multiplier, and the divider is bit-serial
// every request ends with a reciprocal multiply and a one step fix for the fraction
// arst_n returns the registers to their defaults and the table to rest
// a result waits in the output register; a new request is taken meanwhile
// ----------------------------------------------------------------------------
module quarter_turn_motion_profiler
	import qtmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // frame_dt
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // turn_angle, turn_fraction, motion_mode,
	                               // unlock_pulse, lock_pulse, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cfg_t        cfg_q;
	logic        core_ready;
	logic        res_valid;
	logic        res_ready;
	res_t        res;
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_limit <= 18'd19661;
			cfg_q.speed_limit <= 20'd196608;
			cfg_q.lock_wait   <= 24'd163840;
			cfg_q.jerk_rate   <= 18'd32768;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ACCEL_LIMIT: cfg_q.accel_limit <= cfg_data[ACCEL_W-1:0];
				CFG_SPEED_LIMIT: cfg_q.speed_limit <= cfg_data[SPEED_W-1:0];
				CFG_LOCK_WAIT:   cfg_q.lock_wait   <= cfg_data[TIMER_W-1:0];
				CFG_JERK_RATE:   cfg_q.jerk_rate   <= cfg_data[ACCEL_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign s_tready  = core_ready;
	assign res_ready = !m_tvalid_q || m_tready;

	qtmp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid && core_ready),
		.req       (s_tuser),
		.dt        (s_tdata),
		.cfg       (cfg_q),
		.ready     (core_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register parts the core from the result consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
			m_tdata_q  <= {1'b0, res};
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quarter-turn motion profiler. A directed table
// walks reset, refused commands, dwell edges and the first rotation steps;
// random phases under several register settings then drive rotate requests
// and ticks of mixed length. Each result is compared with a fixed point turntable
// model kept in step with each accepted request or with a typed pose.
// ----------------------------------------------------------------------------
module tb_top;
	import qtmp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 12;
	localparam int SETTLE_CYCLES  = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_PHASES     = 8;

	localparam longint unsigned TIMER_CAP = TIMER_MAX;
	localparam longint unsigned ACCEL_CAP = ACCEL_MAX;

	typedef struct {
		logic [1:0]  req;
		logic [15:0] dt;
		bit          typed;
		mode_t       mode;
		bit          unlock;
	} dir_row_t;

	typedef struct {
		int unsigned accel_lim;
		int unsigned speed_lim;
		int unsigned dwell;
		int unsigned jerk;
		int unsigned dt_cap;
		int unsigned items;
		bit          idle;
	} phase_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data  = '0;

	quarter_turn_motion_profiler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// turntable model state and register copies
	longint unsigned cfg_accel = 19661;
	longint unsigned cfg_speed = 196608;
	longint unsigned cfg_dwell = 163840;
	longint unsigned cfg_jerk  = 32768;
	mode_t           tt_mode   = MODE_IDLE;
	longint unsigned tt_angle  = 0;
	longint unsigned tt_speed  = 0;
	longint unsigned tt_accel  = 0;
	longint unsigned tt_timer  = 0;

	res_t        awaited_poses[$];
	int unsigned bad_results   = 0;
	int unsigned poses_checked = 0;
	int unsigned requests_sent = 0;
	int unsigned active_items  = 0;
	int unsigned locks_taken   = 0;
	int unsigned unlocks_taken = 0;
	int unsigned quiet_cycles  = 0;
	int          sink_gap      = 0;
	bit          idle_on       = 1'b1;

	function automatic bit dwell_expired(input longint unsigned dt);
		longint unsigned sum;
		sum = tt_timer + dt;
		tt_timer = (sum > TIMER_CAP) ? TIMER_CAP : sum;
		return sum > cfg_dwell;
	endfunction

	function automatic res_t advance_table(input logic [1:0] req, input longint unsigned dt);
		res_t            pose;
		bit              unl, lck, right, moving;
		longint unsigned target, diff, step, dec, drop;
		unl = 1'b0;
		lck = 1'b0;
		if (req == REQ_TICK && tt_mode != MODE_IDLE)
			active_items++;
		if (req == REQ_LEFT) begin
			if (tt_angle > EPS_CMD_L && tt_mode != MODE_UNL_L) begin
				tt_mode = MODE_UNL_L;
				tt_timer = 0;
				unl = 1'b1;
			end
		end else if (req == REQ_RIGHT) begin
			if (tt_angle + EPS_CMD_L <= HALF_PI_L && tt_mode != MODE_UNL_R) begin
				tt_mode = MODE_UNL_R;
				tt_timer = 0;
				unl = 1'b1;
			end
		end else if (req == REQ_TICK) begin
			if (tt_mode == MODE_UNL_L || tt_mode == MODE_UNL_R) begin
				if (dwell_expired(dt))
					tt_mode = (tt_mode == MODE_UNL_L) ? MODE_ROT_L : MODE_ROT_R;
			end else if (tt_mode == MODE_LCK_L || tt_mode == MODE_LCK_R) begin
				if (dwell_expired(dt))
					tt_mode = MODE_IDLE;
			end
			if (tt_mode == MODE_ROT_L || tt_mode == MODE_ROT_R) begin
				right = (tt_mode == MODE_ROT_R);
				target = right ? HALF_PI_L : 0;
				if ((right && tt_angle + EPS_SNAP_L >= HALF_PI_L) ||
				    (!right && tt_angle <= EPS_SNAP_L)) begin
					// arrival: snap and start the lock dwell
					tt_angle = target;
					tt_speed = 0;
					tt_accel = 0;
					tt_timer = 0;
					tt_mode = right ? MODE_LCK_R : MODE_LCK_L;
					lck = 1'b1;
				end else begin
					moving = 1'b1;
					diff = right ? HALF_PI_L - tt_angle : tt_angle;
					if (64'd4 * diff * cfg_accel > 64'd3 * tt_speed * tt_speed) begin
						tt_accel += (cfg_jerk * dt) >> FRAC_BITS;
						if (tt_accel > cfg_accel)
							tt_accel = cfg_accel;
						tt_speed += (tt_accel * dt) >> FRAC_BITS;
						if (tt_speed > cfg_speed)
							tt_speed = cfg_speed;
					end else begin
						if (diff > EPS_SNAP_L) begin
							dec = (tt_speed * tt_speed) / (64'd2 * diff);
							tt_accel = (dec > ACCEL_CAP) ? ACCEL_CAP : dec;
							drop = (tt_accel * dt) >> FRAC_BITS;
							if (drop >= tt_speed) begin
								tt_speed = 0;
								moving = 1'b0;
							end else
								tt_speed -= drop;
						end else begin
							tt_accel = 0;
							tt_speed = 0;
							moving = 1'b0;
						end
						if (!moving)
							tt_angle = target;
					end
					if (moving) begin
						step = (tt_speed * dt) >> FRAC_BITS;
						if (right)
							tt_angle = (tt_angle + step > HALF_PI_L) ? HALF_PI_L : tt_angle + step;
						else
							tt_angle = (step >= tt_angle) ? 0 : tt_angle - step;
					end
				end
			end
		end
		if (unl) begin
			active_items++;
			unlocks_taken++;
		end
		if (lck)
			locks_taken++;
		pose.turn_angle = OUT_W'(tt_angle);
		pose.turn_fraction = OUT_W'(((tt_angle << FRAC_BITS) + HALF_PI_L / 2) / HALF_PI_L);
		pose.motion_mode = tt_mode;
		pose.unlock_pulse = unl;
		pose.lock_pulse = lck;
		return pose;
	endfunction

	task automatic send_request(input logic [1:0] req, input logic [15:0] dt, input bit typed,
	                            input mode_t typed_mode, input bit typed_unlock);
		int   gap;
		res_t pose;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= dt;
		s_tuser <= req;
		do @(posedge clk); while (!s_tready);
		requests_sent++;
		pose = advance_table(req, dt);
		if (typed) begin
			pose = '0;
			pose.motion_mode = typed_mode;
			pose.unlock_pulse = typed_unlock;
		end
		awaited_poses.push_back(pose);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (awaited_poses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(input phase_t ph);
		logic [1:0]  regs [4];
		logic [23:0] vals [4];
		regs = '{CFG_ACCEL_LIMIT, CFG_SPEED_LIMIT, CFG_LOCK_WAIT, CFG_JERK_RATE};
		vals = '{24'(ph.accel_lim), 24'(ph.speed_lim), 24'(ph.dwell), 24'(ph.jerk)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (regs[i])
				CFG_ACCEL_LIMIT: cfg_accel = vals[i][ACCEL_W-1:0];
				CFG_SPEED_LIMIT: cfg_speed = vals[i][SPEED_W-1:0];
				CFG_LOCK_WAIT:   cfg_dwell = vals[i][TIMER_W-1:0];
				CFG_JERK_RATE:   cfg_jerk  = vals[i][ACCEL_W-1:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			m_tready <= (sink_gap == 1);
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			sink_gap <= $urandom_range(1, 8);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		res_t seen, want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = res_t'(m_tdata[38:0]);
			if (awaited_poses.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("unexpected result: angle %0d fraction %0d mode %0d",
					         seen.turn_angle, seen.turn_fraction, seen.motion_mode);
			end else begin
				want = awaited_poses.pop_front();
				poses_checked++;
				if (seen !== want) begin
					bad_results++;
					if (bad_results <= 10)
						$display({"wrong result %0d (expected/actual): angle %0d/%0d ",
						          "fraction %0d/%0d mode %0d/%0d unlock %0b/%0b lock %0b/%0b"},
						         poses_checked, want.turn_angle, seen.turn_angle,
						         want.turn_fraction, seen.turn_fraction,
						         want.motion_mode, seen.motion_mode,
						         want.unlock_pulse, seen.unlock_pulse,
						         want.lock_pulse, seen.lock_pulse);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("stalled: %0d results still awaited", awaited_poses.size());
				$display("quarter_turn_motion_profiler: mismatch");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t    dir_rows [25];
		phase_t      plan [NUM_PHASES];
		logic [1:0]  req;
		logic [15:0] dt;
		int unsigned pick, goal;

		dir_rows = '{
			'{REQ_TICK,  16'd0,     1'b1, MODE_IDLE,  1'b0},
			'{REQ_LEFT,  16'd0,     1'b1, MODE_IDLE,  1'b0},
			'{2'd3,      16'hFFFF,  1'b1, MODE_IDLE,  1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b1, MODE_IDLE,  1'b0},
			'{REQ_RIGHT, 16'd0,     1'b1, MODE_UNL_R, 1'b1},
			'{REQ_RIGHT, 16'hFFFF,  1'b1, MODE_UNL_R, 1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b1, MODE_UNL_R, 1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b1, MODE_UNL_R, 1'b0},
			'{REQ_TICK,  16'd32770, 1'b1, MODE_UNL_R, 1'b0},
			'{REQ_TICK,  16'd0,     1'b1, MODE_UNL_R, 1'b0},
			'{REQ_TICK,  16'd1,     1'b1, MODE_ROT_R, 1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b0, MODE_IDLE,  1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b0, MODE_IDLE,  1'b0},
			'{REQ_LEFT,  16'd0,     1'b0, MODE_IDLE,  1'b0},
			'{REQ_LEFT,  16'hFFFF,  1'b0, MODE_IDLE,  1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b0, MODE_IDLE,  1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b0, MODE_IDLE,  1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b0, MODE_IDLE,  1'b0},
			'{REQ_TICK,  16'd16384, 1'b0, MODE_IDLE,  1'b0},
			'{REQ_RIGHT, 16'd100,   1'b0, MODE_IDLE,  1'b0},
			'{2'd3,      16'd0,     1'b0, MODE_IDLE,  1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b0, MODE_IDLE,  1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b0, MODE_IDLE,  1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b0, MODE_IDLE,  1'b0},
			'{REQ_TICK,  16'hFFFF,  1'b0, MODE_IDLE,  1'b0}
		};

		plan[0] = '{262143, 655359, 0, 262143, 2048, 150, 1'b1};
		plan[1] = '{0, 196608, 6554, 32768, 16384, 120, 1'b1};
		plan[2] = '{19661, 0, 13107, 0, 8192, 80, 1'b0};
		plan[3] = '{65536, 131072, 16777215, 65536, 65535, 400, 1'b1};
		for (int p = 4; p < NUM_PHASES; p++) begin
			plan[p].accel_lim = $urandom_range(1000, 262143);
			plan[p].speed_lim = $urandom_range(10000, 655359);
			plan[p].dwell = $urandom_range(0, 200000);
			plan[p].jerk = $urandom_range(0, 262143);
			case ($urandom_range(0, 2))
				0:       plan[p].dt_cap = 1024;
				1:       plan[p].dt_cap = 8192;
				default: plan[p].dt_cap = 65535;
			endcase
			plan[p].items = 150;
			plan[p].idle = 1'b1;
		end
		plan[NUM_PHASES-1].idle = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].dt, dir_rows[i].typed,
			             dir_rows[i].mode, dir_rows[i].unlock);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			idle_on = plan[p].idle;
			load_settings(plan[p]);
			goal = active_items + plan[p].items;
			while (active_items < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					dt = 16'd0;
				else if (pick < 12)
					dt = 16'hFFFF;
				else if (pick < 25)
					dt = 16'($urandom_range(0, 65535));
				else
					dt = 16'($urandom_range(0, plan[p].dt_cap));
				pick = $urandom_range(0, 99);
				if (pick < 3)
					req = 2'd3;
				else if (pick < 8)
					req = 2'($urandom_range(REQ_LEFT, REQ_RIGHT));
				else if (tt_mode == MODE_IDLE && pick < 45)
					req = (tt_angle > EPS_CMD_L) ? REQ_LEFT : REQ_RIGHT;
				else
					req = REQ_TICK;
				send_request(req, dt, 1'b0, MODE_IDLE, 1'b0);
			end
		end

		drain_results();
		$display("%0d requests over %0d register settings, %0d results checked",
		         requests_sent, NUM_PHASES + 1, poses_checked);
		$display("%0d unlocks and %0d locks along the way", unlocks_taken, locks_taken);
		if (bad_results == 0 && awaited_poses.size() == 0)
			$display("quarter_turn_motion_profiler: match");
		else
			$display("quarter_turn_motion_profiler: mismatch");
		$finish;
	end

endmodule
